[rtl/kpd_pkg.sv]
// Shared constants for the key press event detector.
// Register indexes, key phase codes, event kinds and reset values.
// No dependencies.
`default_nettype none
package kpd_pkg;

	localparam int NUM_KEYS_DEF    = 2;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int KIND_W    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASK     = 2'd3;

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd3;
	localparam logic [CFG_W-1:0] LONG_RESET     = 16'd100;
	localparam logic [CFG_W-1:0] REPEAT_RESET   = 16'd20;
	localparam int               MASK_RESET     = 1;

	localparam logic [1:0] PH_WAIT     = 2'd0;
	localparam logic [1:0] PH_DEBOUNCE = 2'd1;
	localparam logic [1:0] PH_LONG     = 2'd2;
	localparam logic [1:0] PH_REPEAT   = 2'd3;

	localparam logic [KIND_W-1:0] EV_PRESS         = 3'd0;
	localparam logic [KIND_W-1:0] EV_CLICK_RELEASE = 3'd1;
	localparam logic [KIND_W-1:0] EV_LONG          = 3'd2;
	localparam logic [KIND_W-1:0] EV_REPEAT        = 3'd3;
	localparam logic [KIND_W-1:0] EV_LONG_RELEASE  = 3'd4;

endpackage
`default_nettype wire

[rtl/kpd_front.sv]
// Front part: configuration registers, per-key phase machines and counters.
// Takes one scan tick per request and pushes a record of its events.
// Depends on kpd_pkg.
`default_nettype none
module kpd_front import kpd_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_W-1:0]           cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [NUM_KEYS-1:0]        pin_levels,
	input  wire logic                       queue_full,
	output logic                            push,
	output logic [NUM_KEYS-1:0]             push_hit,
	output logic [NUM_KEYS*KIND_W-1:0]      push_kind
);

	logic [CFG_W-1:0]    debounce_ticks_q;
	logic [CFG_W-1:0]    long_ticks_q;
	logic [CFG_W-1:0]    repeat_ticks_q;
	logic [NUM_KEYS-1:0] active_low_q;

	logic [1:0]       phase_q [NUM_KEYS];
	logic [CFG_W-1:0] deb_q   [NUM_KEYS];
	logic [CFG_W-1:0] long_q  [NUM_KEYS];
	logic [CFG_W-1:0] rep_q   [NUM_KEYS];

	logic [1:0]       phase_d [NUM_KEYS];
	logic [CFG_W-1:0] deb_d   [NUM_KEYS];
	logic [CFG_W-1:0] long_d  [NUM_KEYS];
	logic [CFG_W-1:0] rep_d   [NUM_KEYS];

	logic [NUM_KEYS-1:0] pressed;
	logic                in_accept;

	assign in_ready  = !queue_full;
	assign in_accept = in_valid && in_ready;
	assign pressed   = pin_levels ^ active_low_q;
	assign push      = in_accept && (|push_hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= DEBOUNCE_RESET;
			long_ticks_q     <= LONG_RESET;
			repeat_ticks_q   <= REPEAT_RESET;
			active_low_q     <= NUM_KEYS'(MASK_RESET);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DEBOUNCE: debounce_ticks_q <= cfg_wdata;
				REG_LONG:     long_ticks_q     <= cfg_wdata;
				REG_REPEAT:   repeat_ticks_q   <= cfg_wdata;
				REG_MASK:     active_low_q     <= cfg_wdata[NUM_KEYS-1:0];
			endcase
		end
	end

	// Every key is independent, so all of them step in the same cycle.
	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			phase_d[k] = phase_q[k];
			deb_d[k]   = deb_q[k];
			long_d[k]  = long_q[k];
			rep_d[k]   = rep_q[k];
			push_hit[k] = 1'b0;
			push_kind[k*KIND_W +: KIND_W] = EV_PRESS;
			unique case (phase_q[k])
				PH_WAIT: begin
					if (pressed[k]) phase_d[k] = PH_DEBOUNCE;
				end
				PH_DEBOUNCE: begin
					if (pressed[k]) begin
						deb_d[k] = deb_q[k] - CFG_W'(1);
						if (deb_d[k] == '0) begin
							deb_d[k]    = debounce_ticks_q;
							phase_d[k]  = PH_LONG;
							push_hit[k] = 1'b1;
							push_kind[k*KIND_W +: KIND_W] = EV_PRESS;
						end
					end else begin
						deb_d[k]   = debounce_ticks_q;
						phase_d[k] = PH_WAIT;
					end
				end
				PH_LONG: begin
					if (pressed[k]) begin
						long_d[k] = long_q[k] - CFG_W'(1);
						if (long_d[k] == '0) begin
							long_d[k]   = long_ticks_q;
							phase_d[k]  = PH_REPEAT;
							push_hit[k] = 1'b1;
							push_kind[k*KIND_W +: KIND_W] = EV_LONG;
						end
					end else begin
						long_d[k]   = long_ticks_q;
						phase_d[k]  = PH_WAIT;
						push_hit[k] = 1'b1;
						push_kind[k*KIND_W +: KIND_W] = EV_CLICK_RELEASE;
					end
				end
				PH_REPEAT: begin
					if (pressed[k]) begin
						rep_d[k] = rep_q[k] - CFG_W'(1);
						if (rep_d[k] == '0) begin
							rep_d[k]    = repeat_ticks_q;
							push_hit[k] = 1'b1;
							push_kind[k*KIND_W +: KIND_W] = EV_REPEAT;
						end
					end else begin
						rep_d[k]    = repeat_ticks_q;
						phase_d[k]  = PH_WAIT;
						push_hit[k] = 1'b1;
						push_kind[k*KIND_W +: KIND_W] = EV_LONG_RELEASE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				phase_q[k] <= PH_WAIT;
				deb_q[k]   <= DEBOUNCE_RESET;
				long_q[k]  <= LONG_RESET;
				rep_q[k]   <= REPEAT_RESET;
			end
		end else if (in_accept) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				phase_q[k] <= phase_d[k];
				deb_q[k]   <= deb_d[k];
				long_q[k]  <= long_d[k];
				rep_q[k]   <= rep_d[k];
			end
		end
	end

endmodule
`default_nettype wire

[rtl/kpd_queue.sv]
// Short queue of per-tick event records between the front and back parts.
// Generic width and depth; depends on kpd_pkg for the default width and depth.
// No submodules.
`default_nettype none
module kpd_queue import kpd_pkg::*; #(
	parameter int WIDTH = 2 * (1 + KIND_W),
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = store_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) store_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)      cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

[rtl/kpd_back.sv]
// Back part: takes one tick record at a time and sends its events in key
// order, one per request, marking the last one. Depends on kpd_pkg.
`default_nettype none
module kpd_back import kpd_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF,
	parameter int IDX_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        rec_valid,
	input  wire logic [NUM_KEYS-1:0]         rec_hit,
	input  wire logic [NUM_KEYS*KIND_W-1:0]  rec_kind,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [IDX_W-1:0]                 key_index,
	output logic [KIND_W-1:0]                event_kind,
	output logic                             last_event
);

	logic [NUM_KEYS-1:0]        pend_q;
	logic [NUM_KEYS*KIND_W-1:0] kind_q;
	logic [NUM_KEYS-1:0]        rest;
	logic                       out_accept;

	// Lowest pending key goes first.
	always_comb begin
		key_index = '0;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (pend_q[k]) key_index = IDX_W'(k);
		end
		for (int k = 0; k < NUM_KEYS; k++) begin
			rest[k] = pend_q[k] && (IDX_W'(k) != key_index);
		end
	end

	assign event_kind = kind_q[key_index*KIND_W +: KIND_W];
	assign out_valid  = |pend_q;
	assign last_event = (rest == '0);
	assign out_accept = out_valid && out_ready;
	assign pop        = rec_valid && (!out_valid || (out_accept && last_event));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (pop) begin
			pend_q <= rec_hit;
		end else if (out_accept) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) kind_q <= rec_kind;
	end

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_accept && last_event && !rec_valid) |=> !out_valid)
		else $error("record not drained after its last event");

endmodule
`default_nettype wire

[rtl/key_press_event_detector.sv]
// Top level of the key press event detector: front, queue and back parts.
// Depends on kpd_pkg, kpd_front, kpd_queue and kpd_back.
//
//   channel   direction  handshake            payload
//   config    in         cfg_wr_en            cfg_index, cfg_wdata
//   tick      in         in_valid / in_ready  pin_levels
//   event     out        out_valid/out_ready  key_index, event_kind, last_event
//
// All keys step together in the front part when a tick is taken.
// Each event of a tick is its own transfer on the event channel, so a tick
// with two events needs two transfers; the record queue sets how far ticks
// run ahead of the output. in_ready drops only while the queue is full.
// Reset is asynchronous; no clearing pass is needed after it.
`default_nettype none
module key_press_event_detector import kpd_pkg::*; #(
	parameter int NUM_KEYS    = NUM_KEYS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int IDX_W       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [NUM_KEYS-1:0]  pin_levels,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [IDX_W-1:0]          key_index,
	output logic [KIND_W-1:0]         event_kind,
	output logic                      last_event
);

	localparam int REC_W = NUM_KEYS * (1 + KIND_W);

	logic                       push;
	logic [NUM_KEYS-1:0]        push_hit;
	logic [NUM_KEYS*KIND_W-1:0] push_kind;
	logic                       queue_full;
	logic                       pop;
	logic                       rec_valid;
	logic [REC_W-1:0]           rec_data;

	kpd_front #(.NUM_KEYS(NUM_KEYS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pin_levels (pin_levels),
		.queue_full (queue_full),
		.push       (push),
		.push_hit   (push_hit),
		.push_kind  (push_kind)
	);

	kpd_queue #(.WIDTH(REC_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_kind, push_hit}),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (rec_valid),
		.pop_data  (rec_data)
	);

	kpd_back #(.NUM_KEYS(NUM_KEYS), .IDX_W(IDX_W)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec_valid  (rec_valid),
		.rec_hit    (rec_data[NUM_KEYS-1:0]),
		.rec_kind   (rec_data[REC_W-1:NUM_KEYS]),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_index  (key_index),
		.event_kind (event_kind),
		.last_event (last_event)
	);

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for key_press_event_detector: scan ticks in, key events out.
// The predictor tracks every key's debounce, long-press and repeat counters.
// Depends on kpd_pkg and the detector RTL.
module tb;
	import kpd_pkg::*;

	localparam int NK            = 2;
	localparam int IDX_W         = 1;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 20;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int RX_FREE       = 0;
	localparam int RX_PATTERN    = 1;
	localparam int RX_SLOW       = 2;

	typedef struct packed {
		logic [IDX_W-1:0]  key;
		logic [KIND_W-1:0] kind;
		logic              last;
	} key_event_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CFG_W-1:0]     cfg_wdata  = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [NK-1:0]        pin_levels = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [IDX_W-1:0]     key_index;
	logic [KIND_W-1:0]    event_kind;
	logic                 last_event;

	// Register copies and per-key state of the predictor.
	logic [CFG_W-1:0] debounce_len = DEBOUNCE_RESET;
	logic [CFG_W-1:0] long_len     = LONG_RESET;
	logic [CFG_W-1:0] repeat_len   = REPEAT_RESET;
	logic [NK-1:0]    low_mask     = NK'(MASK_RESET);
	logic [1:0]       key_phase     [NK];
	logic [CFG_W-1:0] debounce_left [NK];
	logic [CFG_W-1:0] long_left     [NK];
	logic [CFG_W-1:0] repeat_left   [NK];

	logic [NK-1:0] pending_ticks[$];
	key_event_t    expected_events[$];
	int            ticks_queued   = 0;
	int            ticks_accepted = 0;
	int            error_count    = 0;
	int            cycle_count    = 0;

	// Hold pattern state of the stimulus generator.
	logic held     [NK];
	int   run_left [NK];

	int         burst_left = 0;
	int         gap_left   = 0;
	int         ready_mode = RX_FREE;
	int         mode_left  = 0;
	logic [7:0] stall_bits = 8'hA5;

	key_press_event_detector u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pin_levels (pin_levels),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_index  (key_index),
		.event_kind (event_kind),
		.last_event (last_event)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	task automatic predict_key_events(input logic [NK-1:0] pins);
		key_event_t        found[$];
		key_event_t        ev;
		logic              pressed;
		logic              fire;
		logic [KIND_W-1:0] kind;
		for (int k = 0; k < NK; k++) begin
			pressed = pins[k] ^ low_mask[k];
			fire = 1'b0;
			kind = EV_PRESS;
			case (key_phase[k])
				PH_WAIT: begin
					if (pressed)
						key_phase[k] = PH_DEBOUNCE;
				end
				PH_DEBOUNCE: begin
					if (pressed) begin
						debounce_left[k] = debounce_left[k] - 1'b1;
						if (debounce_left[k] == '0) begin
							debounce_left[k] = debounce_len;
							key_phase[k] = PH_LONG;
							fire = 1'b1;
							kind = EV_PRESS;
						end
					end else begin
						debounce_left[k] = debounce_len;
						key_phase[k] = PH_WAIT;
					end
				end
				PH_LONG: begin
					if (pressed) begin
						long_left[k] = long_left[k] - 1'b1;
						if (long_left[k] == '0) begin
							long_left[k] = long_len;
							key_phase[k] = PH_REPEAT;
							fire = 1'b1;
							kind = EV_LONG;
						end
					end else begin
						long_left[k] = long_len;
						key_phase[k] = PH_WAIT;
						fire = 1'b1;
						kind = EV_CLICK_RELEASE;
					end
				end
				PH_REPEAT: begin
					if (pressed) begin
						repeat_left[k] = repeat_left[k] - 1'b1;
						if (repeat_left[k] == '0) begin
							repeat_left[k] = repeat_len;
							fire = 1'b1;
							kind = EV_REPEAT;
						end
					end else begin
						repeat_left[k] = repeat_len;
						key_phase[k] = PH_WAIT;
						fire = 1'b1;
						kind = EV_LONG_RELEASE;
					end
				end
			endcase
			if (fire) begin
				ev.key = k[IDX_W-1:0];
				ev.kind = kind;
				ev.last = 1'b0;
				found.push_back(ev);
			end
		end
		if (found.size() != 0)
			found[found.size()-1].last = 1'b1;
		foreach (found[i])
			expected_events.push_back(found[i]);
	endtask

	task automatic queue_pins(input logic [NK-1:0] pins);
		pending_ticks.push_back(pins);
		ticks_queued++;
	endtask

	task automatic queue_pressed(input logic [NK-1:0] pressed);
		queue_pins(pressed ^ low_mask);
	endtask

	// Each key alternates between released stretches and holds; some holds are
	// short bounces, the rest run up to 40 ticks to reach long press and repeats.
	task automatic queue_hold_ticks(input int count, input int noise_pct);
		logic [NK-1:0] press;
		for (int t = 0; t < count; t++) begin
			for (int k = 0; k < NK; k++) begin
				if (run_left[k] == 0) begin
					held[k] = !held[k];
					if (!held[k])
						run_left[k] = $urandom_range(1, 4);
					else if ($urandom_range(0, 4) == 0)
						run_left[k] = $urandom_range(1, 3);
					else
						run_left[k] = $urandom_range(1, 40);
				end
				run_left[k]--;
				press[k] = held[k];
			end
			if ($urandom_range(1, 100) <= noise_pct)
				queue_pins(NK'($urandom_range(0, 3)));
			else
				queue_pressed(press);
		end
	endtask

	task automatic wait_drained();
		while (ticks_queued != ticks_accepted || in_valid || expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_DEBOUNCE: debounce_len = data;
			REG_LONG:     long_len = data;
			REG_REPEAT:   repeat_len = data;
			REG_MASK:     low_mask = data[NK-1:0];
		endcase
	endtask

	// The mask word carries random upper bits, which the block must drop.
	task automatic set_config(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
			input logic [CFG_W-1:0] rpt, input logic [NK-1:0] mask);
		logic [CFG_W-1:0] mask_word;
		mask_word = {(CFG_W-NK)'($urandom), mask};
		wait_drained();
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_LONG, lng);
		write_reg(REG_REPEAT, rpt);
		write_reg(REG_MASK, mask_word);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	always @(posedge clk) begin : driver
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_key_events(pin_levels);
				ticks_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					in_valid <= 1'b1;
					pin_levels <= pending_ticks.pop_front();
					if (burst_left == 0)
						burst_left = $urandom_range(1, 24);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		key_event_t want;
		logic       go;
		if (arst_n && out_valid && out_ready) begin
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("event key %0d kind %0d with none expected",
					key_index, event_kind));
			end else begin
				want = expected_events.pop_front();
				if (key_index !== want.key)
					report_mismatch($sformatf("key_index %0d, expected %0d", key_index, want.key));
				if (event_kind !== want.kind)
					report_mismatch($sformatf("event_kind %0d, expected %0d", event_kind,
						want.kind));
				if (last_event !== want.last)
					report_mismatch($sformatf("last_event %0b, expected %0b", last_event,
						want.last));
			end
		end
		if (mode_left == 0) begin
			ready_mode = $urandom_range(RX_FREE, RX_SLOW);
			mode_left = $urandom_range(4, 60);
			stall_bits = 8'($urandom);
		end
		mode_left--;
		stall_bits = {stall_bits[6:0], stall_bits[7]};
		case (ready_mode)
			RX_FREE:    go = 1'b1;
			RX_PATTERN: go = stall_bits[0];
			default:    go = ($urandom_range(0, 3) == 0);
		endcase
		out_ready <= go;
	end

	initial begin
		for (int k = 0; k < NK; k++) begin
			key_phase[k] = PH_WAIT;
			debounce_left[k] = DEBOUNCE_RESET;
			long_left[k] = LONG_RESET;
			repeat_left[k] = REPEAT_RESET;
			held[k] = 1'b0;
			run_left[k] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: bounces, then both keys confirm together and click.
		queue_pins(2'b00);
		queue_pins(2'b11);
		queue_pressed(2'b00);
		queue_pressed(2'b01);
		queue_pressed(2'b00);
		repeat (4) queue_pressed(2'b11);
		queue_pressed(2'b00);
		repeat (5) queue_pressed(2'b10);
		queue_pressed(2'b00);

		// Short counters; the debounce, long and repeat counters still hold the old reload.
		set_config(16'd1, 16'd2, 16'd1, 2'b10);
		queue_pressed(2'b00);
		repeat (8) queue_pressed(2'b11);
		queue_pressed(2'b01);
		queue_pressed(2'b00);
		repeat (3) queue_pressed(2'b01);
		queue_pressed(2'b00);

		set_config(16'd1, 16'd1, 16'd1, 2'b00);
		queue_hold_ticks(60, 10);
		set_config(16'hFFFF, 16'd2, 16'd1, 2'b11);
		queue_hold_ticks(60, 10);
		for (int p = 0; p < 6; p++) begin
			set_config(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 6)),
				CFG_W'($urandom_range(1, 6)), NK'($urandom_range(0, 3)));
			queue_hold_ticks(60, 10);
		end

		// A zero length acts as 65536 ticks once the counter has been reloaded,
		// so a hold of a few dozen ticks makes no further event from it.
		set_config(16'd0, 16'hFFFF, 16'd0, 2'b01);
		repeat (2) queue_pressed(2'b00);
		queue_pressed(2'b11);
		queue_pressed(2'b00);
		queue_pressed(2'b11);
		repeat (24) queue_pressed(2'b11);
		queue_pressed(2'b00);
		queue_pressed(2'b10);
		queue_pressed(2'b00);

		while (ticks_queued != ticks_accepted || in_valid || expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
rtl/kpd_pkg.sv
rtl/kpd_front.sv
rtl/kpd_queue.sv
rtl/kpd_back.sv
rtl/key_press_event_detector.sv
sim/tb.sv
